FILE: hdl/ctbw_pkg.sv
// Shared types and constants for the clipped tile block writer.
package ctbw_pkg;

   // Field widths
   localparam int POS_W  = 8;
   localparam int CODE_W = 8;
   localparam int ADDR_W = 10;
   // Signed working width for clip arithmetic (covers -128..254)
   localparam int CALC_W = 10;

   // Request kinds carried in req_tuser
   localparam logic OP_SINGLE = 1'b0;
   localparam logic OP_BLOCK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic setup;   // compute clip window and start values
      logic emit;    // write one cell to the output register and advance
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;      // nothing visible
      logic last_cell;  // current cell is the final visible one
      logic slot_free;  // output register can take a beat
   } sts_type;

endpackage

FILE: hdl/clipped_tile_block_writer_unit.sv
// A request beat is taken in the idle state; the setup state computes the clip window
// and start values, then the run state writes one cell per cycle from the walk counters
// while the output register can take a beat. A wholly clipped request returns to idle
// after setup. A waiting final beat does not block the next request.
// Reset (synchronous, active high) clears the controller and the output valid.
module clipped_tile_block_writer_unit #(
   parameter int WINDOW_WIDTH  = 32,
   parameter int WINDOW_HEIGHT = 24,
   parameter int BLOCK_SIZE    = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pos_x[7:0], pos_y[15:8], code[23:16]
   input  logic        req_tuser,  // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // cell_address[9:0], cell_code[17:10], zero[23:18]
   output logic        rsp_tlast
);

   ctbw_pkg::cmd_type cmd;
   ctbw_pkg::sts_type sts;
   logic [ctbw_pkg::ADDR_W-1:0] cell_address;
   logic [ctbw_pkg::CODE_W-1:0] cell_code;

   ctbw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ctbw_dp #(
      .WINDOW_WIDTH  (WINDOW_WIDTH),
      .WINDOW_HEIGHT (WINDOW_HEIGHT),
      .BLOCK_SIZE    (BLOCK_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_op      (req_tuser),
      .req_pos_x   (req_tdata[7:0]),
      .req_pos_y   (req_tdata[15:8]),
      .req_code    (req_tdata[23:16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_address (cell_address),
      .rsp_code    (cell_code),
      .rsp_last    (rsp_tlast)
   );

   // Pack result beat
   assign rsp_tdata = {6'b0, cell_code, cell_address};

endmodule

FILE: hdl/ctbw_ctrl.sv
// Controller state machine for the clipped tile block writer.
module ctbw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ctbw_pkg::sts_type sts,
   output ctbw_pkg::cmd_type cmd
);

   ctbw_pkg::state_type state_ff;
   ctbw_pkg::state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctbw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctbw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ctbw_pkg::ST_SETUP;
            end
         end
         ctbw_pkg::ST_SETUP: begin
            if (sts.empty) begin
               state_in = ctbw_pkg::ST_IDLE;
            end else begin
               state_in = ctbw_pkg::ST_RUN;
            end
         end
         ctbw_pkg::ST_RUN: begin
            if (sts.slot_free && sts.last_cell) begin
               state_in = ctbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctbw_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ctbw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ctbw_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ctbw_pkg::ST_RUN: begin
            cmd.emit = sts.slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: hdl/ctbw_dp.sv
// Datapath: clip window, cell walk counters and output register.
module ctbw_dp #(
   parameter int WINDOW_WIDTH  = 32,
   parameter int WINDOW_HEIGHT = 24,
   parameter int BLOCK_SIZE    = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_op,
   input  logic [ctbw_pkg::POS_W-1:0]  req_pos_x,
   input  logic [ctbw_pkg::POS_W-1:0]  req_pos_y,
   input  logic [ctbw_pkg::CODE_W-1:0] req_code,
   input  ctbw_pkg::cmd_type           cmd,
   output ctbw_pkg::sts_type           sts,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ctbw_pkg::ADDR_W-1:0] rsp_address,
   output logic [ctbw_pkg::CODE_W-1:0] rsp_code,
   output logic                        rsp_last
);

   localparam int CW = $clog2(BLOCK_SIZE + 1);
   localparam int AW = ctbw_pkg::ADDR_W;
   localparam int DW = ctbw_pkg::CODE_W;
   localparam int XW = ctbw_pkg::CALC_W;

   // Captured request
   logic                   op_ff;
   logic signed [ctbw_pkg::POS_W-1:0] x_ff;
   logic signed [ctbw_pkg::POS_W-1:0] y_ff;
   logic [DW-1:0]          code_ff;

   // Walk state
   logic [CW-1:0] k_ff, k0_ff, k1_ff, r_ff, r1_ff;
   logic [AW-1:0] col_ff, col0_ff, row_addr_ff;
   logic [DW-1:0] cur_code_ff, row_code_ff;

   // Output register
   logic          out_valid_ff;
   logic [AW-1:0] out_addr_ff;
   logic [DW-1:0] out_code_ff;
   logic          out_last_ff;

   // Clip arithmetic
   logic signed [XW-1:0] xs, ys, ext, lim_x, lim_y;
   logic signed [XW-1:0] k0s, k1s, r0s, r1s;
   logic signed [XW-1:0] col_start, row_start;
   logic [AW-1:0]        row_addr_start;
   logic [DW-1:0]        code_start;
   logic                 row_end;

   always_comb begin
      xs    = XW'(x_ff);
      ys    = XW'(y_ff);
      ext   = (op_ff == ctbw_pkg::OP_BLOCK) ? XW'(BLOCK_SIZE - 1) : '0;
      lim_x = XW'(WINDOW_WIDTH - 1) - xs;
      lim_y = XW'(WINDOW_HEIGHT - 1) - ys;
      k0s   = xs[XW-1] ? -xs : '0;
      r0s   = ys[XW-1] ? -ys : '0;
      k1s   = (lim_x < ext) ? lim_x : ext;
      r1s   = (lim_y < ext) ? lim_y : ext;
      col_start      = xs + k0s;
      row_start      = ys + r0s;
      row_addr_start = row_start[AW-1:0] * AW'(WINDOW_WIDTH);
      code_start     = code_ff + DW'(r0s[CW-1:0]) * DW'(BLOCK_SIZE) + DW'(k0s[CW-1:0]);
   end

   assign row_end = (k_ff == k1_ff);

   assign sts.empty     = (k0s > k1s) || (r0s > r1s);
   assign sts.last_cell = row_end && (r_ff == r1_ff);
   assign sts.slot_free = !out_valid_ff || rsp_ready;

   // Capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         code_ff <= req_code;
      end
   end

   // Load start values, then advance along the row and down the block
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         k0_ff       <= k0s[CW-1:0];
         k_ff        <= k0s[CW-1:0];
         k1_ff       <= k1s[CW-1:0];
         r_ff        <= r0s[CW-1:0];
         r1_ff       <= r1s[CW-1:0];
         col0_ff     <= col_start[AW-1:0];
         col_ff      <= col_start[AW-1:0];
         row_addr_ff <= row_addr_start;
         row_code_ff <= code_start;
         cur_code_ff <= code_start;
      end else if (cmd.emit) begin
         if (row_end) begin
            k_ff        <= k0_ff;
            r_ff        <= r_ff + CW'(1);
            col_ff      <= col0_ff;
            row_addr_ff <= row_addr_ff + AW'(WINDOW_WIDTH);
            row_code_ff <= row_code_ff + DW'(BLOCK_SIZE);
            cur_code_ff <= row_code_ff + DW'(BLOCK_SIZE);
         end else begin
            k_ff        <= k_ff + CW'(1);
            col_ff      <= col_ff + AW'(1);
            cur_code_ff <= cur_code_ff + DW'(1);
         end
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_addr_ff <= row_addr_ff + col_ff;
         out_code_ff <= cur_code_ff;
         out_last_ff <= sts.last_cell;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_code    = out_code_ff;
   assign rsp_last    = out_last_ff;

endmodule

FILE: tb/clipped_tile_block_writer_unit_tb.sv
// Self-checking testbench for the clipped tile block writer: directed and random requests.
`timescale 1ns / 100ps

module clipped_tile_block_writer_unit_tb;

   localparam int WIN_W        = 32;
   localparam int WIN_H        = 24;
   localparam int BLK          = 6;
   localparam int RANDOM_ITEMS = 96;
   localparam int QUIET_TAIL   = 20;
   // Watchdog limit for a stretch without a beat on either side
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PW           = ctbw_pkg::POS_W;
   localparam int CDW          = ctbw_pkg::CODE_W;
   localparam int AW           = ctbw_pkg::ADDR_W;

   // One buffer write as it leaves the block
   typedef struct packed {
      logic [AW-1:0]  addr;
      logic [CDW-1:0] code;
      logic           last;
   } cell_write_type;

   // One row of the directed plan; fixed rows carry their own expectation
   typedef struct packed {
      logic           op;
      logic [PW-1:0]  pos_x;
      logic [PW-1:0]  pos_y;
      logic [CDW-1:0] code;
      logic           fixed;
      logic           has_write;
      logic [AW-1:0]  addr;
      logic [CDW-1:0] cell_code;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // pos_x[7:0], pos_y[15:8], code[23:16]
   logic        req_tuser;   // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // cell_address[9:0], cell_code[17:10], zero[23:18]
   logic        rsp_tlast;

   cell_write_type writes_due[$];
   plan_row_type   plan[$];
   int             mismatches;
   int             idle_cycles;
   bit             quiet;

   clipped_tile_block_writer_unit #(
      .WINDOW_WIDTH  (WIN_W),
      .WINDOW_HEIGHT (WIN_H),
      .BLOCK_SIZE    (BLK)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic note_mismatch(input string what);
      $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   // Work out the visible cell writes of one request and queue them in order
   function automatic void predict_writes(input logic op, input logic [PW-1:0] pos_x,
                                          input logic [PW-1:0] pos_y,
                                          input logic [CDW-1:0] code);
      cell_write_type batch[$];
      cell_write_type cw;
      int left;
      int top;
      int span;
      int row;
      int col;
      left = $signed(pos_x);
      top  = $signed(pos_y);
      span = (op == ctbw_pkg::OP_BLOCK) ? BLK : 1;
      for (int r = 0; r < span; r++) begin
         for (int k = 0; k < span; k++) begin
            row = top + r;
            col = left + k;
            if (col >= 0 && col < WIN_W && row >= 0 && row < WIN_H) begin
               cw.addr = AW'(row * WIN_W + col);
               cw.code = CDW'(int'(code) + r * BLK + k);
               cw.last = 1'b0;
               batch.push_back(cw);
            end
         end
      end
      for (int i = 0; i < batch.size(); i++) begin
         cw = batch[i];
         cw.last = (i == batch.size() - 1);
         writes_due.push_back(cw);
      end
   endfunction

   task automatic add_row(input logic op, input int x, input int y, input int code,
                          input int fixed, input int has_write,
                          input int addr, input int cell_code);
      plan_row_type pr;
      pr.op        = op;
      pr.pos_x     = PW'(x);
      pr.pos_y     = PW'(y);
      pr.code      = CDW'(code);
      pr.fixed     = (fixed != 0);
      pr.has_write = (has_write != 0);
      pr.addr      = AW'(addr);
      pr.cell_code = CDW'(cell_code);
      plan.push_back(pr);
   endtask

   // Present one request beat, with an optional gap first, and hold until taken
   task automatic send_request(input logic op, input logic [PW-1:0] pos_x,
                               input logic [PW-1:0] pos_y,
                               input logic [CDW-1:0] code);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 8);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {code, pos_y, pos_x};
      do @(posedge clock); while (!req_tready);
   endtask

   // Result-side back-pressure in random bursts
   initial begin : ready_gen
      int burst_left;
      burst_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            burst_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_tready <= 1'b1;
            burst_left = $urandom_range(1, 24) - 1;
         end
      end
   end

   // Compare each write beat with the oldest one due
   always @(posedge clock) begin : write_check
      cell_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (writes_due.size() == 0) begin
            note_mismatch($sformatf("unexpected write addr %0d code %0d last %0d",
                                    rsp_tdata[9:0], rsp_tdata[17:10], rsp_tlast));
         end else begin
            want = writes_due.pop_front();
            if (rsp_tdata[9:0] !== want.addr || rsp_tdata[17:10] !== want.code ||
                rsp_tlast !== want.last)
               note_mismatch($sformatf("write addr %0d code %0d last %0d, wanted %0d %0d %0d",
                                       rsp_tdata[9:0], rsp_tdata[17:10], rsp_tlast,
                                       want.addr, want.code, want.last));
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("clipped_tile_block_writer_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      cell_write_type cw;
      plan_row_type   pr;
      logic           op;
      logic [7:0]     px;
      logic [7:0]     py;
      int             vx;
      int             vy;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      mismatches  = 0;
      quiet       = 1'b0;

      // Corners, edges and fully clipped requests carry fixed expectations
      add_row(ctbw_pkg::OP_SINGLE,    0,    0, 8'h00, 1, 1,   0, 8'h00);
      add_row(ctbw_pkg::OP_SINGLE,   31,   23, 8'hFF, 1, 1, 767, 8'hFF);
      add_row(ctbw_pkg::OP_SINGLE,   31,    0, 8'h5A, 1, 1,  31, 8'h5A);
      add_row(ctbw_pkg::OP_SINGLE,   -1,    0, 8'h11, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_SINGLE,   32,    0, 8'h22, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_SINGLE,    0,   -1, 8'h33, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_SINGLE,    0,   24, 8'h44, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_SINGLE, -128, -128, 8'h80, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_SINGLE,  127,  127, 8'h7F, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    -6,    0, 8'h01, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    32,    0, 8'h02, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,     0,   -6, 8'h03, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,     0,   24, 8'h04, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,  -128, -128, 8'h05, 1, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,   127,  127, 8'h06, 1, 0,   0, 0);
      // A single cell and blocks with clipping on each side and code wrap go to the predictor
      add_row(ctbw_pkg::OP_SINGLE,    5,    7, 8'hA5, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,     0,    0, 8'h00, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    26,   18, 8'hFF, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    -5,   -5, 8'h10, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    -3,   -2, 8'hF0, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    29,   21, 8'hFE, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    -2,   10, 8'h80, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    10,   -3, 8'hDD, 0, 0,   0, 0);
      add_row(ctbw_pkg::OP_BLOCK,    31,   23, 8'hFA, 0, 0,   0, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part
      foreach (plan[i]) begin
         pr = plan[i];
         send_request(pr.op, pr.pos_x, pr.pos_y, pr.code);
         if (!pr.fixed) begin
            predict_writes(pr.op, pr.pos_x, pr.pos_y, pr.code);
         end else if (pr.has_write) begin
            cw.addr = pr.addr;
            cw.code = pr.cell_code;
            cw.last = 1'b1;
            writes_due.push_back(cw);
         end
      end

      // Hold off the sender until the block has drained
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (writes_due.size() == 0);

      // Random part: mostly near the window, some anywhere in range
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait (writes_due.size() == 0);
         end
         quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
         op = ($urandom_range(0, 9) < 7) ? ctbw_pkg::OP_BLOCK : ctbw_pkg::OP_SINGLE;
         if ($urandom_range(0, 3) == 0) begin
            px = PW'($urandom_range(0, 255));
            py = PW'($urandom_range(0, 255));
         end else begin
            vx = int'($urandom_range(0, WIN_W + 10)) - 8;
            vy = int'($urandom_range(0, WIN_H + 10)) - 8;
            px = PW'(vx);
            py = PW'(vy);
         end
         cw.code = CDW'($urandom_range(0, 255));
         send_request(op, px, py, cw.code);
         predict_writes(op, px, py, cw.code);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then allow for any late stray beat
      wait (writes_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (writes_due.size() != 0)
         note_mismatch($sformatf("%0d writes never arrived", writes_due.size()));

      if (mismatches == 0) begin
         $display("clipped_tile_block_writer_unit: match");
      end else begin
         $display("clipped_tile_block_writer_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ctbw_pkg.sv
hdl/ctbw_ctrl.sv
hdl/ctbw_dp.sv
hdl/clipped_tile_block_writer_unit.sv
tb/clipped_tile_block_writer_unit_tb.sv
